/* sv/hhlp_pkg.sv */
// Package for the HTTP header line parser: byte and class codes, count width
// and the result word types shared by the parser, the queue and the interfaces.
// No dependencies.
`default_nettype none

package hhlp_pkg;

  // Width of the saturating byte counter
  localparam int CountWidth = 16;
  localparam int ConsumedWidth = 16;

  // Characters that steer the parse
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;

  // Byte classes
  typedef enum logic [1:0] {
    ClsName  = 2'd0,
    ClsValue = 2'd1,
    ClsDelim = 2'd2,
    ClsTerm  = 2'd3
  } cls_e;

  // Block status
  typedef enum logic [1:0] {
    StRunning = 2'd0,
    StDone    = 2'd1,
    StError   = 2'd2
  } status_e;

  // One result word
  typedef struct packed {
    logic [7:0]               out_byte;
    logic [1:0]               byte_class;
    logic                     line_done;
    logic [1:0]               status;
    logic [ConsumedWidth-1:0] consumed;
    logic                     last_of_run;
  } res_t;

  // Words released by one input byte: zero, one or two
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } step_t;

endpackage

`default_nettype wire

/* sv/hhlp_if.sv */
// Stream interfaces of the HTTP header line parser: input bytes and result words.
// Depends on hhlp_pkg.
`default_nettype none

interface hhlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface hhlp_out_if;
  logic                              valid;
  logic                              ready;
  logic [7:0]                        out_byte;
  logic [1:0]                        byte_class;
  logic                              line_done;
  logic [1:0]                        status;
  logic [hhlp_pkg::ConsumedWidth-1:0] consumed;
  logic                              last_of_run;

  modport source (output valid, out_byte, byte_class, line_done, status, consumed,
                  last_of_run, input ready);
  modport sink   (input valid, out_byte, byte_class, line_done, status, consumed,
                  last_of_run, output ready);
endinterface

`default_nettype wire

/* sv/http_header_line_parser_unit.sv */
// Top level of the HTTP header line parser: parse state machine feeding a
// result queue. Depends on hhlp_pkg, hhlp_if, hhlp_parser and hhlp_out_queue.
`default_nettype none

// Classifies a header block one byte per cycle, when the queue has room, into
// name, value, delimiter and terminator words. A byte that releases one word or
// none is taken every cycle while the sink keeps up; a byte that also releases
// a held ':' or CR gives two words, and since the result port sends one word a
// cycle while the sink is ready, such bytes cannot be taken back to back. A
// three-entry result queue sits between the parser and the result port, and the
// input is ready whenever at most one word is queued, so a byte can still be
// taken while a word waits on a stalled sink. No clearing pass; ready out of reset.
module http_header_line_parser_unit (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  hhlp_in_if.sink     in_i,
  hhlp_out_if.source  res_o
);

  hhlp_pkg::step_t step;
  hhlp_pkg::res_t  head;
  logic            acc;
  logic            room;
  logic            pop;
  logic            q_valid;

  assign in_i.ready = room;
  assign acc        = in_i.valid && room;
  assign pop        = q_valid && res_o.ready;

  // Classify the accepted byte
  hhlp_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .data_i  (in_i.data_byte),
    .first_i (in_i.first_byte),
    .last_i  (in_i.last_byte),
    .step_o  (step)
  );

  // Queue result words toward the sink
  hhlp_out_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (acc),
    .step_i  (step),
    .room_o  (room),
    .valid_o (q_valid),
    .pop_i   (pop),
    .head_o  (head)
  );

  assign res_o.valid       = q_valid;
  assign res_o.out_byte    = head.out_byte;
  assign res_o.byte_class  = head.byte_class;
  assign res_o.line_done   = head.line_done;
  assign res_o.status      = head.status;
  assign res_o.consumed    = head.consumed;
  assign res_o.last_of_run = head.last_of_run;

endmodule

`default_nettype wire

/* sv/hhlp_parser.sv */
// Parse state machine: classifies each accepted byte with one byte of
// lookahead and forms up to two result words. Depends on hhlp_pkg.
`default_nettype none

module hhlp_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             acc_i,
  input  wire logic [7:0]       data_i,
  input  wire logic             first_i,
  input  wire logic             last_i,
  output hhlp_pkg::step_t       step_o
);

  typedef enum logic [2:0] {
    PhLine, PhName, PhColon, PhLsCr, PhValue, PhVCr, PhDone, PhErr
  } phase_e;

  phase_e                             phase_q, phase_d, ph;
  logic [7:0]                         held_q, held_d, held;
  logic [hhlp_pkg::CountWidth-1:0]    count_q, count_d, cnt;
  logic                               active;
  logic [1:0]                         num;
  logic [7:0]                         b0, b1;
  hhlp_pkg::cls_e                     c0, c1;
  logic                               ld1;
  hhlp_pkg::status_e                  st;

  // Next state and released words for the byte on the input
  always_comb begin
    ph   = first_i ? PhLine : phase_q;
    held = first_i ? 8'h00 : held_q;
    cnt  = first_i ? '0 : count_q;
    active = !(ph == PhDone || ph == PhErr);
    phase_d = ph;
    held_d  = held;
    count_d = cnt;
    num = 2'd0;
    b0 = held;
    b1 = data_i;
    c0 = hhlp_pkg::ClsName;
    c1 = hhlp_pkg::ClsName;
    ld1 = 1'b0;
    if (active) begin
      count_d = (cnt != '1) ? cnt + 1'b1 : cnt;
      unique case (ph)
        PhLine: begin
          if (data_i == hhlp_pkg::ChCr) begin
            held_d = data_i;
            phase_d = PhLsCr;
          end else if (data_i == hhlp_pkg::ChColon) begin
            held_d = data_i;
            phase_d = PhColon;
          end else begin
            num = 2'd1;
            b0 = data_i;
            phase_d = PhName;
          end
        end
        PhName: begin
          if (data_i == hhlp_pkg::ChColon) begin
            held_d = data_i;
            phase_d = PhColon;
          end else begin
            num = 2'd1;
            b0 = data_i;
          end
        end
        PhColon: begin
          if (data_i == hhlp_pkg::ChSpace) begin
            num = 2'd2;
            c0 = hhlp_pkg::ClsDelim;
            c1 = hhlp_pkg::ClsDelim;
            phase_d = PhValue;
          end else if (data_i == hhlp_pkg::ChColon) begin
            num = 2'd1;
            held_d = data_i;
          end else begin
            num = 2'd2;
            phase_d = PhName;
          end
        end
        PhLsCr: begin
          if (data_i == hhlp_pkg::ChLf) begin
            num = 2'd2;
            c0 = hhlp_pkg::ClsTerm;
            c1 = hhlp_pkg::ClsTerm;
            phase_d = PhDone;
          end else if (data_i == hhlp_pkg::ChColon) begin
            num = 2'd1;
            held_d = data_i;
            phase_d = PhColon;
          end else begin
            num = 2'd2;
            phase_d = PhName;
          end
        end
        PhValue: begin
          if (data_i == hhlp_pkg::ChCr) begin
            held_d = data_i;
            phase_d = PhVCr;
          end else begin
            num = 2'd1;
            b0 = data_i;
            c0 = hhlp_pkg::ClsValue;
          end
        end
        PhVCr: begin
          if (data_i == hhlp_pkg::ChLf) begin
            num = 2'd2;
            c0 = hhlp_pkg::ClsDelim;
            c1 = hhlp_pkg::ClsDelim;
            ld1 = 1'b1;
            phase_d = PhLine;
          end else if (data_i == hhlp_pkg::ChCr) begin
            num = 2'd1;
            c0 = hhlp_pkg::ClsValue;
            held_d = data_i;
          end else begin
            num = 2'd2;
            c0 = hhlp_pkg::ClsValue;
            c1 = hhlp_pkg::ClsValue;
            phase_d = PhValue;
          end
        end
        default: begin
          num = 2'd0;
        end
      endcase

      // End of buffer: finish at a line start, else flush any held byte and fail
      if (last_i && phase_d != PhDone) begin
        if (phase_d == PhLine) begin
          phase_d = PhDone;
        end else begin
          if (phase_d == PhColon || phase_d == PhLsCr || phase_d == PhVCr) begin
            if (num == 2'd0) begin
              b0 = held_d;
              c0 = (phase_d == PhVCr) ? hhlp_pkg::ClsValue : hhlp_pkg::ClsName;
            end else begin
              b1 = held_d;
              c1 = (phase_d == PhVCr) ? hhlp_pkg::ClsValue : hhlp_pkg::ClsName;
              ld1 = 1'b0;
            end
            num = num + 2'd1;
          end
          phase_d = PhErr;
        end
      end
    end
  end

  // Build result words; all words of one byte carry the same status and count
  always_comb begin
    st = (phase_d == PhDone) ? hhlp_pkg::StDone :
         (phase_d == PhErr)  ? hhlp_pkg::StError : hhlp_pkg::StRunning;
    step_o.num            = num;
    step_o.r0.out_byte    = b0;
    step_o.r0.byte_class  = c0;
    step_o.r0.line_done   = 1'b0;
    step_o.r0.status      = st;
    step_o.r0.consumed    = hhlp_pkg::ConsumedWidth'(count_d);
    step_o.r0.last_of_run = (num == 2'd1);
    step_o.r1.out_byte    = b1;
    step_o.r1.byte_class  = c1;
    step_o.r1.line_done   = ld1;
    step_o.r1.status      = st;
    step_o.r1.consumed    = hhlp_pkg::ConsumedWidth'(count_d);
    step_o.r1.last_of_run = 1'b1;
  end

  // Hold parse state; advance on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhLine;
      held_q  <= 8'h00;
      count_q <= '0;
    end else if (acc_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      count_q <= count_d;
    end
  end

  // A held byte is always the character that put the parser in its phase
  a_held_colon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhColon) |-> (held_q == hhlp_pkg::ChColon))
    else $error("colon phase without held colon");

  a_held_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhLsCr || phase_q == PhVCr) |-> (held_q == hhlp_pkg::ChCr))
    else $error("CR phase without held CR");

  // A finished block releases nothing until a new buffer starts
  a_dead_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && !first_i && (phase_q == PhDone || phase_q == PhErr)) |=>
      (phase_q == $past(phase_q) && count_q == $past(count_q)))
    else $error("state changed after block end");

  a_num_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i |-> (step_o.num != 2'd3))
    else $error("more than two words for one byte");

endmodule

`default_nettype wire

/* sv/hhlp_out_queue.sv */
// Three-entry result queue: takes up to two words per input byte, sends one
// word per cycle while the sink is ready. Depends on hhlp_pkg.
`default_nettype none

module hhlp_out_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  hhlp_pkg::step_t      step_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  wire logic            pop_i,
  output hhlp_pkg::res_t       head_o
);

  localparam int Depth = 3;

  hhlp_pkg::res_t q_q [Depth];
  hhlp_pkg::res_t q_d [Depth];
  logic [1:0]     cnt_q, cnt_d, cnt_s;

  // Room for two words regardless of the output side
  assign room_o  = (cnt_q <= 2'd1);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = q_q[0];

  // Shift out the head on pop, then append the new words behind the rest
  always_comb begin
    cnt_s  = pop_i ? cnt_q - 2'd1 : cnt_q;
    q_d[0] = pop_i ? q_q[1] : q_q[0];
    q_d[1] = pop_i ? q_q[2] : q_q[1];
    q_d[2] = q_q[2];
    cnt_d  = cnt_s;
    if (push_i) begin
      if (step_i.num != 2'd0) q_d[cnt_s] = step_i.r0;
      if (step_i.num == 2'd2) q_d[cnt_s + 2'd1] = step_i.r1;
      cnt_d = cnt_s + step_i.num;
    end
  end

  // Hold fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Hold entries
  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q <= 2'd1))
    else $error("push without room");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != 2'd0))
    else $error("pop from empty queue");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!push_i && !pop_i) |=> $stable(cnt_q))
    else $error("fill count moved without push or pop");

endmodule

`default_nettype wire
